// File: design/hstk_pkg.sv
// shared types, constants and helpers for the hashed score top-k retainer
`default_nettype none

package hstk_pkg;

    localparam int CAPACITY   = 6;
    localparam int INDEX_BITS = 20;
    localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [19:0] INDEX_MASK     = 20'((64'd1 << INDEX_BITS) - 64'd1);
    localparam logic [4:0]  CAPACITY_COUNT = 5'(CAPACITY);

    localparam logic [31:0] HASH_GOLDEN  = 32'h9e3779b9;
    localparam logic [31:0] HASH_MIX_A   = 32'h7feb352d;
    localparam logic [31:0] HASH_MIX_B   = 32'h846ca68b;
    localparam logic [31:0] MOD_BASE     = 32'd97;
    localparam logic [31:0] MOD_RECIP    = 32'((64'd1 << 32) / 64'd97);
    localparam logic [31:0] DEPTH_WEIGHT = 32'd100;

    localparam logic [31:0] RESET_HASH_SEED   = 32'd0;
    localparam logic [15:0] RESET_MIN_DEPTH   = 16'd4;
    localparam logic [7:0]  RESET_MAX_PRECIP  = 8'd64;
    localparam logic [7:0]  RESET_SALT_PRECIP = 8'd27;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_HASH_SEED   = 2'd0,
        CFG_MIN_DEPTH   = 2'd1,
        CFG_MAX_PRECIP  = 2'd2,
        CFG_SALT_PRECIP = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [19:0] label;
        logic [20:0] area;
        logic [19:0] sink;
        logic [7:0]  precip;
        logic [22:0] score;
        logic [63:0] tie;
    } slot_entry_t;

    typedef struct packed {
        logic clear;
        logic offer;
    } list_ctrl_t;

    typedef struct packed {
        logic       done;
        logic       placed;
        logic [3:0] slot;
    } list_status_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  placed_slot;
        logic [4:0]  kept_total;
        logic        entry_valid;
        logic [19:0] entry_label;
        logic [20:0] entry_area;
        logic [19:0] entry_sink;
        logic [7:0]  entry_precip;
        logic [22:0] entry_score;
        logic        entry_salt;
    } result_t;

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_MUL_LABEL,
        SC_MUL_MIX_A,
        SC_MUL_MIX_B,
        SC_MUL_RECIP,
        SC_MUL_QUOT,
        SC_MUL_DEPTH,
        SC_SUM,
        SC_DONE
    } score_state_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_CHECK_LAST,
        L_SHIFT
    } list_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_DECODE,
        T_SCORE,
        T_WALK,
        T_EMIT
    } top_state_t;

    function automatic logic ranks_before(
        input logic [22:0] score_a,
        input logic [63:0] tie_a,
        input logic [22:0] score_b,
        input logic [63:0] tie_b
    );
        return (score_a > score_b) || ((score_a == score_b) && (tie_a < tie_b));
    endfunction

endpackage

`default_nettype wire

// File: design/hashed_score_top_k_retainer_unit.sv
// top level of the hashed score top-k retainer
`default_nettype none

// Keeps the best six scored candidates sorted by score, highest first, lower tie key
// first on equal scores. One word is taken at a time and in_stall stays high until
// its result has moved into the output register. Clear, read and unused commands, and
// an offer that fails qualification, go from decode straight to the output stage. A
// qualified offer first goes to the hash and score, which pass six times through one
// shared 32x32 multiplier (label mix, two hash rounds, reciprocal and back-multiply for
// the modulo 97, depth weight); then the insertion walk compares and moves one slot per
// cycle. On a full list the walk first checks the last entry, and an offer that does
// not beat it is not placed. A result waits for the output register while the one
// before it is still held by out_stall. The slot store has no reset and is never
// cleared; only slots below the kept count are read. The next word may be accepted
// while a result still waits on out_stall.
module hashed_score_top_k_retainer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [19:0] label,
    input  wire logic [20:0] area,
    input  wire logic [19:0] sink,
    input  wire logic [15:0] peak_depth,
    input  wire logic [7:0]  mean_precip,
    input  wire logic        near_water,
    input  wire logic [63:0] tie_key,
    input  wire logic [3:0]  read_slot,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic [3:0]       placed_slot,
    output logic [4:0]       kept_total,
    output logic             entry_valid,
    output logic [19:0]      entry_label,
    output logic [20:0]      entry_area,
    output logic [19:0]      entry_sink,
    output logic [7:0]       entry_precip,
    output logic [22:0]      entry_score,
    output logic             entry_salt
);

    hstk_pkg::top_state_t state_reg, state_next;

    logic [31:0] hash_seed_reg;
    logic [15:0] min_depth_reg;
    logic [7:0]  max_precip_reg;
    logic [7:0]  salt_precip_reg;

    logic [1:0]  cmd_reg;
    logic [19:0] label_reg;
    logic [20:0] area_reg;
    logic [19:0] sink_reg;
    logic [15:0] depth_reg;
    logic [7:0]  precip_reg;
    logic        near_reg;
    logic [63:0] tie_reg;
    logic [3:0]  rslot_reg;

    hstk_pkg::result_t res_reg, res_next;
    hstk_pkg::result_t out_reg;
    logic              out_valid_reg;

    logic in_accept;
    logic qualified;
    logic out_load;
    logic score_start;
    logic score_done;
    logic [22:0] score_val;

    hstk_pkg::list_ctrl_t   list_ctrl;
    hstk_pkg::list_status_t list_status;
    hstk_pkg::slot_entry_t  new_entry;
    hstk_pkg::slot_entry_t  rd_entry;
    logic [4:0]             list_kept;
    logic                   rd_valid;

    assign in_stall  = (state_reg != hstk_pkg::T_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign qualified = (depth_reg >= min_depth_reg) && (precip_reg <= max_precip_reg) &&
                       !near_reg;

    assign new_entry.label  = label_reg;
    assign new_entry.area   = area_reg;
    assign new_entry.sink   = sink_reg;
    assign new_entry.precip = precip_reg;
    assign new_entry.score  = score_val;
    assign new_entry.tie    = tie_reg;

    hstk_score_unit u_score (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (score_start),
        .label      (label_reg),
        .depth      (depth_reg),
        .precip     (precip_reg),
        .seed       (hash_seed_reg),
        .max_precip (max_precip_reg),
        .done       (score_done),
        .score      (score_val)
    );

    hstk_slot_list u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (list_ctrl),
        .new_entry  (new_entry),
        .rd_slot    (rslot_reg),
        .status     (list_status),
        .kept_count (list_kept),
        .rd_valid   (rd_valid),
        .rd_entry   (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg   <= hstk_pkg::RESET_HASH_SEED;
            min_depth_reg   <= hstk_pkg::RESET_MIN_DEPTH;
            max_precip_reg  <= hstk_pkg::RESET_MAX_PRECIP;
            salt_precip_reg <= hstk_pkg::RESET_SALT_PRECIP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hstk_pkg::CFG_HASH_SEED:   hash_seed_reg   <= cfg_data;
                hstk_pkg::CFG_MIN_DEPTH:   min_depth_reg   <= cfg_data[15:0];
                hstk_pkg::CFG_MAX_PRECIP:  max_precip_reg  <= cfg_data[7:0];
                hstk_pkg::CFG_SALT_PRECIP: salt_precip_reg <= cfg_data[7:0];
                default:                   hash_seed_reg   <= hash_seed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hstk_pkg::T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg    <= cmd;
            label_reg  <= label & hstk_pkg::INDEX_MASK;
            area_reg   <= area;
            sink_reg   <= sink & hstk_pkg::INDEX_MASK;
            depth_reg  <= peak_depth;
            precip_reg <= mean_precip;
            near_reg   <= near_water;
            tie_reg    <= tie_key;
            rslot_reg  <= read_slot;
        end
        res_reg <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        res_next    = res_reg;
        list_ctrl   = '0;
        score_start = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            hstk_pkg::T_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = hstk_pkg::T_DECODE;
                end
            end
            hstk_pkg::T_DECODE:
            begin
                res_next            = '0;
                res_next.kept_total = list_kept;
                state_next          = hstk_pkg::T_EMIT;
                unique case (cmd_reg)
                    hstk_pkg::CMD_CLEAR:
                    begin
                        list_ctrl.clear     = 1'b1;
                        res_next.kept_total = '0;
                    end
                    hstk_pkg::CMD_OFFER:
                    begin
                        if (qualified)
                        begin
                            score_start = 1'b1;
                            state_next  = hstk_pkg::T_SCORE;
                        end
                    end
                    hstk_pkg::CMD_READ:
                    begin
                        if (rd_valid)
                        begin
                            res_next.entry_valid  = 1'b1;
                            res_next.entry_label  = rd_entry.label;
                            res_next.entry_area   = rd_entry.area;
                            res_next.entry_sink   = rd_entry.sink;
                            res_next.entry_precip = rd_entry.precip;
                            res_next.entry_score  = rd_entry.score;
                            res_next.entry_salt   = (rd_entry.precip <= salt_precip_reg);
                        end
                    end
                    default:
                    begin
                        res_next.kept_total = list_kept;
                    end
                endcase
            end
            hstk_pkg::T_SCORE:
            begin
                if (score_done)
                begin
                    list_ctrl.offer = 1'b1;
                    state_next      = hstk_pkg::T_WALK;
                end
            end
            hstk_pkg::T_WALK:
            begin
                if (list_status.done)
                begin
                    res_next.accepted    = list_status.placed;
                    res_next.placed_slot = list_status.slot;
                    res_next.kept_total  = list_kept;
                    state_next           = hstk_pkg::T_EMIT;
                end
            end
            hstk_pkg::T_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = hstk_pkg::T_IDLE;
                end
            end
            default:
            begin
                state_next = hstk_pkg::T_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_reg.accepted;
    assign placed_slot  = out_reg.placed_slot;
    assign kept_total   = out_reg.kept_total;
    assign entry_valid  = out_reg.entry_valid;
    assign entry_label  = out_reg.entry_label;
    assign entry_area   = out_reg.entry_area;
    assign entry_sink   = out_reg.entry_sink;
    assign entry_precip = out_reg.entry_precip;
    assign entry_score  = out_reg.entry_score;
    assign entry_salt   = out_reg.entry_salt;

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        list_kept <= hstk_pkg::CAPACITY_COUNT)
        else $error("kept count beyond capacity");

    a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
        list_status.done |-> (state_reg == hstk_pkg::T_WALK))
        else $error("list walk finished outside walk phase");

    a_score_done: assert property (@(posedge clk) disable iff (!rst_n)
        score_done |-> (state_reg == hstk_pkg::T_SCORE))
        else $error("score finished outside score phase");

    a_placed_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> ({1'b0, placed_slot} < kept_total))
        else $error("placed slot not below kept total");

endmodule

`default_nettype wire

// File: design/hstk_score_unit.sv
// hash and score sequencer around one shared 32x32 multiplier
`default_nettype none

module hstk_score_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [19:0] label,
    input  wire logic [15:0] depth,
    input  wire logic [7:0]  precip,
    input  wire logic [31:0] seed,
    input  wire logic [7:0]  max_precip,
    output logic             done,
    output logic [22:0]      score
);

    hstk_pkg::score_state_t state_reg, state_next;

    logic [63:0] prod_reg, prod_next;
    logic [31:0] hash_reg;
    logic [7:0]  rem_reg;
    logic [22:0] score_reg;

    logic [31:0] mul_a, mul_b;
    logic        mul_en;
    logic [31:0] v_seed, v_pre_a, v_pre_b, h_val, rem_full;
    logic [8:0]  margin;
    logic [9:0]  margin3;
    logic [22:0] sum_val;

    assign prod_next = 64'(mul_a) * 64'(mul_b);

    assign v_seed   = seed ^ prod_reg[31:0];
    assign v_pre_a  = v_seed ^ (v_seed >> 16);
    assign v_pre_b  = prod_reg[31:0] ^ (prod_reg[31:0] >> 15);
    assign h_val    = prod_reg[31:0] ^ (prod_reg[31:0] >> 16);
    assign rem_full = hash_reg - prod_reg[31:0];

    assign margin  = {1'b0, max_precip} + 9'd1 - {1'b0, precip};
    assign margin3 = ({1'b0, margin} << 1) + {1'b0, margin};
    assign sum_val = prod_reg[22:0] + 23'(margin3) + 23'(rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hstk_pkg::SC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == hstk_pkg::SC_MUL_RECIP)
        begin
            hash_reg <= h_val;
        end
        if (state_reg == hstk_pkg::SC_MUL_DEPTH)
        begin
            rem_reg <= (rem_full >= hstk_pkg::MOD_BASE) ?
                       8'(rem_full - hstk_pkg::MOD_BASE) : 8'(rem_full);
        end
        if (state_reg == hstk_pkg::SC_SUM)
        begin
            score_reg <= sum_val;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        mul_en     = 1'b0;
        unique case (state_reg)
            hstk_pkg::SC_IDLE:
            begin
                if (start)
                begin
                    state_next = hstk_pkg::SC_MUL_LABEL;
                end
            end
            hstk_pkg::SC_MUL_LABEL:
            begin
                mul_a      = {12'd0, label};
                mul_b      = hstk_pkg::HASH_GOLDEN;
                mul_en     = 1'b1;
                state_next = hstk_pkg::SC_MUL_MIX_A;
            end
            hstk_pkg::SC_MUL_MIX_A:
            begin
                mul_a      = v_pre_a;
                mul_b      = hstk_pkg::HASH_MIX_A;
                mul_en     = 1'b1;
                state_next = hstk_pkg::SC_MUL_MIX_B;
            end
            hstk_pkg::SC_MUL_MIX_B:
            begin
                mul_a      = v_pre_b;
                mul_b      = hstk_pkg::HASH_MIX_B;
                mul_en     = 1'b1;
                state_next = hstk_pkg::SC_MUL_RECIP;
            end
            hstk_pkg::SC_MUL_RECIP:
            begin
                mul_a      = h_val;
                mul_b      = hstk_pkg::MOD_RECIP;
                mul_en     = 1'b1;
                state_next = hstk_pkg::SC_MUL_QUOT;
            end
            hstk_pkg::SC_MUL_QUOT:
            begin
                mul_a      = prod_reg[63:32];
                mul_b      = hstk_pkg::MOD_BASE;
                mul_en     = 1'b1;
                state_next = hstk_pkg::SC_MUL_DEPTH;
            end
            hstk_pkg::SC_MUL_DEPTH:
            begin
                mul_a      = {16'd0, depth};
                mul_b      = hstk_pkg::DEPTH_WEIGHT;
                mul_en     = 1'b1;
                state_next = hstk_pkg::SC_SUM;
            end
            hstk_pkg::SC_SUM:
            begin
                state_next = hstk_pkg::SC_DONE;
            end
            hstk_pkg::SC_DONE:
            begin
                state_next = hstk_pkg::SC_IDLE;
            end
            default:
            begin
                state_next = hstk_pkg::SC_IDLE;
            end
        endcase
    end

    assign done  = (state_reg == hstk_pkg::SC_DONE);
    assign score = score_reg;

endmodule

`default_nettype wire

// File: design/hstk_slot_list.sv
// sorted slot list with one read port, one write port and a one-slot-per-cycle insertion walk
`default_nettype none

module hstk_slot_list (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hstk_pkg::list_ctrl_t  ctrl,
    input  wire hstk_pkg::slot_entry_t new_entry,
    input  wire logic [3:0]            rd_slot,
    output hstk_pkg::list_status_t     status,
    output logic [4:0]                 kept_count,
    output logic                       rd_valid,
    output hstk_pkg::slot_entry_t      rd_entry
);

    hstk_pkg::list_state_t state_reg, state_next;

    logic [hstk_pkg::SLOT_BITS-1:0] cursor_reg, cursor_next;
    logic [4:0]                     kept_reg, kept_next;

    hstk_pkg::slot_entry_t slots_reg [hstk_pkg::CAPACITY];

    logic                           wr_en;
    logic [hstk_pkg::SLOT_BITS-1:0] wr_addr;
    hstk_pkg::slot_entry_t          wr_data;
    logic [hstk_pkg::SLOT_BITS-1:0] rd_addr;
    hstk_pkg::slot_entry_t          cur_entry;
    logic                           beats;

    assign cur_entry = slots_reg[rd_addr];
    assign beats     = hstk_pkg::ranks_before(new_entry.score, new_entry.tie,
                                              cur_entry.score, cur_entry.tie);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hstk_pkg::L_IDLE;
            cursor_reg <= '0;
            kept_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            kept_reg   <= kept_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        kept_next   = kept_reg;
        wr_en       = 1'b0;
        wr_addr     = cursor_reg;
        wr_data     = new_entry;
        rd_addr     = rd_slot[hstk_pkg::SLOT_BITS-1:0];
        status      = '0;
        unique case (state_reg)
            hstk_pkg::L_IDLE:
            begin
                if (ctrl.clear)
                begin
                    kept_next = '0;
                end
                else if (ctrl.offer)
                begin
                    if (kept_reg < hstk_pkg::CAPACITY_COUNT)
                    begin
                        cursor_next = kept_reg[hstk_pkg::SLOT_BITS-1:0];
                        kept_next   = kept_reg + 5'd1;
                        state_next  = hstk_pkg::L_SHIFT;
                    end
                    else
                    begin
                        cursor_next = hstk_pkg::SLOT_BITS'(hstk_pkg::CAPACITY - 1);
                        state_next  = hstk_pkg::L_CHECK_LAST;
                    end
                end
            end
            hstk_pkg::L_CHECK_LAST:
            begin
                // full list: the offer must beat the last entry
                rd_addr = cursor_reg;
                if (beats)
                begin
                    state_next = hstk_pkg::L_SHIFT;
                end
                else
                begin
                    status.done = 1'b1;
                    state_next  = hstk_pkg::L_IDLE;
                end
            end
            hstk_pkg::L_SHIFT:
            begin
                rd_addr = cursor_reg - hstk_pkg::SLOT_BITS'(1);
                if ((cursor_reg != '0) && beats)
                begin
                    wr_en       = 1'b1;
                    wr_data     = cur_entry;
                    cursor_next = cursor_reg - hstk_pkg::SLOT_BITS'(1);
                end
                else
                begin
                    wr_en         = 1'b1;
                    status.done   = 1'b1;
                    status.placed = 1'b1;
                    status.slot   = 4'(cursor_reg);
                    state_next    = hstk_pkg::L_IDLE;
                end
            end
            default:
            begin
                state_next = hstk_pkg::L_IDLE;
            end
        endcase
    end

    assign kept_count = kept_reg;
    assign rd_valid   = ({1'b0, rd_slot} < kept_reg) &&
                        ({1'b0, rd_slot} < hstk_pkg::CAPACITY_COUNT);
    assign rd_entry   = cur_entry;

endmodule

`default_nettype wire

// File: dv/retainer_checker.sv
// checker for the hashed score top-k retainer: tracks the kept list and compares every result word
module retainer_checker
    import hstk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [19:0] label,
    input  logic [20:0] area,
    input  logic [19:0] sink,
    input  logic [15:0] peak_depth,
    input  logic [7:0]  mean_precip,
    input  logic        near_water,
    input  logic [63:0] tie_key,
    input  logic [3:0]  read_slot,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        accepted,
    input  logic [3:0]  placed_slot,
    input  logic [4:0]  kept_total,
    input  logic        entry_valid,
    input  logic [19:0] entry_label,
    input  logic [20:0] entry_area,
    input  logic [19:0] entry_sink,
    input  logic [7:0]  entry_precip,
    input  logic [22:0] entry_score,
    input  logic        entry_salt,
    output int          pending,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] LABEL_SPREAD = 32'h9e3779b9;
    localparam logic [31:0] MIX_FIRST    = 32'h7feb352d;
    localparam logic [31:0] MIX_SECOND   = 32'h846ca68b;

    typedef struct packed {
        logic [19:0] label;
        logic [20:0] area;
        logic [19:0] sink;
        logic [7:0]  precip;
        logic [22:0] score;
        logic [63:0] tie;
    } kept_entry_t;

    logic [31:0] seed_reg;
    logic [15:0] min_depth_reg;
    logic [7:0]  max_precip_reg;
    logic [7:0]  salt_precip_reg;

    kept_entry_t kept_list [CAPACITY];
    int          kept_count;
    result_t     due_results [$];
    int          errs;

    function automatic logic [31:0] mix32(input logic [31:0] v);
        logic [31:0] x;
        x = v ^ (v >> 16);
        x = x * MIX_FIRST;
        x = x ^ (x >> 15);
        x = x * MIX_SECOND;
        return x ^ (x >> 16);
    endfunction

    function automatic logic outranks(input logic [22:0] sa, input logic [63:0] ta,
                                      input logic [22:0] sb, input logic [63:0] tb);
        return (sa > sb) || ((sa == sb) && (ta < tb));
    endfunction

    function automatic logic [31:0] candidate_score(input logic [19:0] lbl,
                                                    input logic [15:0] depth,
                                                    input logic [7:0] precip);
        logic [31:0] h;
        logic [31:0] margin;
        h = mix32(seed_reg ^ ({12'd0, lbl} * LABEL_SPREAD));
        margin = {24'd0, max_precip_reg} + 32'd1 - {24'd0, precip};
        return {16'd0, depth} * 32'd100 + margin * 32'd3 + (h % 32'd97);
    endfunction

    task automatic apply_word(output result_t r);
        logic [31:0] s;
        int          pos;
        logic        fits;
        r = '0;
        case (cmd)
            CMD_CLEAR: kept_count = 0;
            CMD_OFFER:
            begin
                if (peak_depth >= min_depth_reg && mean_precip <= max_precip_reg && !near_water)
                begin
                    s = candidate_score(label, peak_depth, mean_precip);
                    fits = 1'b1;
                    if (kept_count < CAPACITY)
                    begin
                        pos = kept_count;
                        kept_count++;
                    end
                    else
                    begin
                        pos = CAPACITY - 1;
                        fits = outranks(s[22:0], tie_key, kept_list[pos].score,
                                        kept_list[pos].tie);
                    end
                    if (fits)
                    begin
                        while (pos > 0 && outranks(s[22:0], tie_key, kept_list[pos - 1].score,
                                                   kept_list[pos - 1].tie))
                        begin
                            kept_list[pos] = kept_list[pos - 1];
                            pos--;
                        end
                        kept_list[pos] = '{label, area, sink, mean_precip, s[22:0], tie_key};
                        r.accepted = 1'b1;
                        r.placed_slot = 4'(pos);
                    end
                end
            end
            CMD_READ:
            begin
                if (int'(read_slot) < kept_count)
                begin
                    r.entry_valid = 1'b1;
                    r.entry_label = kept_list[read_slot].label;
                    r.entry_area = kept_list[read_slot].area;
                    r.entry_sink = kept_list[read_slot].sink;
                    r.entry_precip = kept_list[read_slot].precip;
                    r.entry_score = kept_list[read_slot].score;
                    r.entry_salt = (kept_list[read_slot].precip <= salt_precip_reg);
                end
            end
            default: ;
        endcase
        r.kept_total = 5'(kept_count);
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            seed_reg = RESET_HASH_SEED;
            min_depth_reg = RESET_MIN_DEPTH;
            max_precip_reg = RESET_MAX_PRECIP;
            salt_precip_reg = RESET_SALT_PRECIP;
            kept_count = 0;
            due_results.delete();
            errs = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    errs++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("accepted", want.accepted, accepted);
                    check_field("placed_slot", want.placed_slot, placed_slot);
                    check_field("kept_total", want.kept_total, kept_total);
                    check_field("entry_valid", want.entry_valid, entry_valid);
                    check_field("entry_label", want.entry_label, entry_label);
                    check_field("entry_area", want.entry_area, entry_area);
                    check_field("entry_sink", want.entry_sink, entry_sink);
                    check_field("entry_precip", want.entry_precip, entry_precip);
                    check_field("entry_score", want.entry_score, entry_score);
                    check_field("entry_salt", want.entry_salt, entry_salt);
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_HASH_SEED:   seed_reg = cfg_data;
                    CFG_MIN_DEPTH:   min_depth_reg = cfg_data[15:0];
                    CFG_MAX_PRECIP:  max_precip_reg = cfg_data[7:0];
                    CFG_SALT_PRECIP: salt_precip_reg = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                apply_word(want);
                due_results.push_back(want);
            end
            pending <= due_results.size();
            fail_count <= errs;
        end
    end

endmodule

// File: dv/testbench.sv
// testbench top for the hashed score top-k retainer: stimulus, handshakes and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hstk_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_WORDS = 200;
    localparam int PHASES = 8;

    typedef struct {
        logic [1:0]  cmd;
        logic [19:0] label;
        logic [20:0] area;
        logic [19:0] sink;
        logic [15:0] depth;
        logic [7:0]  precip;
        logic        near;
        logic [63:0] tie;
        logic [3:0]  slot;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_HASH_SEED;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_CLEAR;
    logic [19:0] label = '0;
    logic [20:0] area = '0;
    logic [19:0] sink = '0;
    logic [15:0] peak_depth = '0;
    logic [7:0]  mean_precip = '0;
    logic        near_water = 1'b0;
    logic [63:0] tie_key = '0;
    logic [3:0]  read_slot = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic [3:0]  placed_slot;
    logic [4:0]  kept_total;
    logic        entry_valid;
    logic [19:0] entry_label;
    logic [20:0] entry_area;
    logic [19:0] entry_sink;
    logic [7:0]  entry_precip;
    logic [22:0] entry_score;
    logic        entry_salt;
    int          pending;
    int          fail_count;

    bit          quiet_gaps = 1'b0;
    int          cur_min_depth = RESET_MIN_DEPTH;
    int          cur_max_precip = RESET_MAX_PRECIP;

    hashed_score_top_k_retainer_unit DUT (.*);
    retainer_checker checker_i (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL hashed_score_top_k_retainer_unit");
        $finish;
    end

    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = quiet_gaps ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
        end
    end

    function automatic word_t offer(input logic [19:0] lbl, input logic [20:0] ar,
                                    input logic [19:0] snk, input logic [15:0] depth,
                                    input logic [7:0] precip, input logic near,
                                    input logic [63:0] tie);
        word_t w;
        w = '{CMD_OFFER, lbl, ar, snk, depth, precip, near, tie, 4'd0};
        return w;
    endfunction

    function automatic word_t command(input logic [1:0] c, input logic [3:0] slot);
        word_t w;
        w = '{c, 20'd0, 21'd0, 20'd0, 16'd0, 8'd0, 1'b0, 64'd0, slot};
        return w;
    endfunction

    function automatic word_t random_word();
        word_t w;
        int    pick;
        int    d;
        w.label = 20'($urandom);
        w.area = 21'($urandom_range(0, 1048576));
        w.sink = 20'($urandom);
        w.depth = 16'($urandom);
        w.precip = 8'($urandom);
        w.near = 1'($urandom);
        w.tie = {$urandom, $urandom};
        w.slot = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            w.cmd = CMD_CLEAR;
        else if (pick < 7)
            w.cmd = CMD_UNUSED;
        else if (pick < 45)
            w.cmd = CMD_READ;
        else
            w.cmd = CMD_OFFER;
        if (w.cmd == CMD_READ && $urandom_range(0, 3) != 0)
            w.slot = 4'($urandom_range(0, CAPACITY - 1));
        if (w.cmd == CMD_OFFER && $urandom_range(0, 4) != 0)
        begin
            w.near = 1'b0;
            if ($urandom_range(0, 3) == 0)
            begin
                // few labels and tie keys so equal scores come up
                d = cur_min_depth + $urandom_range(0, 1);
                w.label = 20'($urandom_range(0, 1));
                w.precip = 8'(cur_max_precip - ((cur_max_precip > 0) ? $urandom_range(0, 1) : 0));
                if ($urandom_range(0, 1) == 0)
                    w.tie = 64'($urandom_range(0, 7));
            end
            else
            begin
                d = cur_min_depth + $urandom_range(0, 40);
                w.precip = 8'($urandom_range(0, cur_max_precip));
            end
            w.depth = 16'((d > 65535) ? 65535 : d);
        end
        return w;
    endfunction

    task automatic send_word(input word_t w);
        int gap;
        gap = quiet_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd <= w.cmd;
        label <= w.label;
        area <= w.area;
        sink <= w.sink;
        peak_depth <= w.depth;
        mean_precip <= w.precip;
        near_water <= w.near;
        tie_key <= w.tie;
        read_slot <= w.slot;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] seed, input logic [31:0] min_d,
                                input logic [31:0] max_p, input logic [31:0] salt_p);
        cfg_index_t  idx [4];
        logic [31:0] vals [4];
        idx = '{CFG_HASH_SEED, CFG_MIN_DEPTH, CFG_MAX_PRECIP, CFG_SALT_PRECIP};
        vals = '{seed, min_d, max_p, salt_p};
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            if (i == 0)
                cfg_write <= 1'b1;
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cur_min_depth = min_d[15:0];
        cur_max_precip = max_p[7:0];
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(command(CMD_CLEAR, 4'd0));
        send_word(command(CMD_READ, 4'd0));
        send_word(offer(20'd1, 21'd10, 20'd2, 16'd3, 8'd10, 1'b0, 64'd1));
        send_word(offer(20'd1, 21'd10, 20'd2, 16'd10, 8'd65, 1'b0, 64'd1));
        send_word(offer(20'd1, 21'd10, 20'd2, 16'd10, 8'd10, 1'b1, 64'd1));
        send_word(offer(20'd5, 21'd100, 20'd7, 16'd10, 8'd20, 1'b0, 64'd100));
        send_word(offer(20'd5, 21'd101, 20'd8, 16'd10, 8'd20, 1'b0, 64'd50));
        send_word(offer(20'd5, 21'd102, 20'd9, 16'd10, 8'd20, 1'b0, 64'd200));
        send_word(offer(20'hfffff, 21'd1048576, 20'hfffff, 16'hffff, 8'd0, 1'b0, '1));
        send_word(offer(20'd0, 21'd0, 20'd0, 16'd4, 8'd64, 1'b0, 64'd0));
        send_word(offer(20'd7, 21'd3, 20'd4, 16'd20, 8'd27, 1'b0, 64'd9));
        send_word(offer(20'd0, 21'd1, 20'd1, 16'd4, 8'd64, 1'b0, '1));
        send_word(offer(20'd0, 21'd2, 20'd2, 16'd4, 8'd64, 1'b0, 64'd0));
        send_word(offer(20'd9, 21'd55, 20'd66, 16'd5, 8'd30, 1'b0, 64'd3));
        for (int s = 0; s < CAPACITY + 1; s++)
            send_word(command(CMD_READ, 4'(s)));
        send_word(command(CMD_READ, 4'd15));
        send_word(command(CMD_UNUSED, 4'd2));
        send_word(command(CMD_CLEAR, 4'd0));
        send_word(command(CMD_READ, 4'd0));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: program_regs(32'd0, 32'd0, 32'd255, 32'd255);
                1: program_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ff00, 32'h0);
                2: program_regs($urandom, 32'd4, 32'd64, 32'd27);
                default: program_regs($urandom, {16'($urandom), 16'($urandom_range(0, 2000))},
                                      $urandom, $urandom);
            endcase
            quiet_gaps = (ph == 2 || ph == 5);
            repeat (PHASE_WORDS) send_word(random_word());
            wait_drained();
        end
        quiet_gaps = 1'b0;
        repeat (24) @(posedge clk);

        if (fail_count == 0)
            $display("PASS hashed_score_top_k_retainer_unit");
        else
            $display("FAIL hashed_score_top_k_retainer_unit");
        $finish;
    end

endmodule
